@@ hdl/aarb_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// aarb_pkg
// Shared types and constants for the axis-angle rotation matrix builder.
// ---------------------------------------------------------------------------
package aarb_pkg;

    // Angle units are 1/64 degree
    localparam logic signed [17:0] TURN_UNITS      = 18'sd23040;
    localparam logic signed [17:0] TWO_TURN_UNITS  = 18'sd46080;
    localparam logic signed [17:0] HALF_UNITS      = 18'sd11520;
    localparam logic signed [17:0] QUARTER_UNITS   = 18'sd5760;

    // Q62 pi/4 divided by 2880: one angle unit in Q62 radians
    localparam logic [50:0] ANGLE_K = 51'd1257642267027279;

    localparam logic signed [33:0] Q30_ONE = 34'sd1073741824;

    // Job handed from the front to the back: unit axis, cosine, sine, degenerate flag
    typedef struct packed {
        logic signed [32:0] ux;
        logic signed [32:0] uy;
        logic signed [32:0] uz;
        logic signed [31:0] c;
        logic signed [31:0] s;
        logic               degen;
    } t_rot_job;

    // Control of a bit-serial unit
    typedef struct packed {
        logic load;
        logic step;
    } t_iter_ctl;

    // atan(2^-i) in Q30 radians, rounded
    function automatic logic [31:0] atan_q30(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'd843314857;
            5'd1:  v = 32'd497837829;
            5'd2:  v = 32'd263043837;
            5'd3:  v = 32'd133525159;
            5'd4:  v = 32'd67021687;
            5'd5:  v = 32'd33543516;
            5'd6:  v = 32'd16775851;
            5'd7:  v = 32'd8388437;
            5'd8:  v = 32'd4194283;
            5'd9:  v = 32'd2097149;
            5'd10: v = 32'd1048576;
            5'd11: v = 32'd524288;
            5'd12: v = 32'd262144;
            5'd13: v = 32'd131072;
            5'd14: v = 32'd65536;
            5'd15: v = 32'd32768;
            5'd16: v = 32'd16384;
            5'd17: v = 32'd8192;
            5'd18: v = 32'd4096;
            5'd19: v = 32'd2048;
            5'd20: v = 32'd1024;
            5'd21: v = 32'd512;
            5'd22: v = 32'd256;
            5'd23: v = 32'd128;
            5'd24: v = 32'd64;
            5'd25: v = 32'd32;
            5'd26: v = 32'd16;
            5'd27: v = 32'd8;
            5'd28: v = 32'd4;
            5'd29: v = 32'd2;
            default: v = 32'd1;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

@@ hdl/aarb_isqrt.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// aarb_isqrt
// Bit-serial floor square root of a 64-bit value, one root bit per step.
// ---------------------------------------------------------------------------
module aarb_isqrt (
    input  logic                 i_clk,
    input  aarb_pkg::t_iter_ctl  i_ctl,
    input  logic [63:0]          i_val,
    output logic [31:0]          o_root
);

    logic [63:0] r_val;
    logic [33:0] r_rem;
    logic [31:0] r_root;
    logic [35:0] n_rem_sh;
    logic [35:0] n_trial;

    assign n_rem_sh = {r_rem, r_val[63:62]};
    assign n_trial  = {2'b00, r_root, 2'b01};
    assign o_root   = r_root;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_val  <= i_val;
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_ctl.step) begin
            r_val <= {r_val[61:0], 2'b00};
            if (n_rem_sh >= n_trial) begin
                r_rem  <= 34'(n_rem_sh - n_trial);
                r_root <= {r_root[30:0], 1'b1};
            end else begin
                r_rem  <= n_rem_sh[33:0];
                r_root <= {r_root[30:0], 1'b0};
            end
        end
    end

endmodule
`default_nettype wire

@@ hdl/aarb_div.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// aarb_div
// Restoring divider, 64-bit numerator by 32-bit divisor, 32 quotient bits,
// one bit per step. The upper numerator word must be below the divisor.
// ---------------------------------------------------------------------------
module aarb_div (
    input  logic                 i_clk,
    input  aarb_pkg::t_iter_ctl  i_ctl,
    input  logic [63:0]          i_num,
    input  logic [31:0]          i_den,
    output logic [31:0]          o_quo
);

    logic [31:0] r_rem;
    logic [31:0] r_low;
    logic [31:0] r_den;
    logic [31:0] r_quo;
    logic [32:0] n_sh;

    assign n_sh  = {r_rem, r_low[31]};
    assign o_quo = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_rem <= i_num[63:32];
            r_low <= i_num[31:0];
            r_den <= i_den;
            r_quo <= '0;
        end else if (i_ctl.step) begin
            r_low <= {r_low[30:0], 1'b0};
            if (n_sh >= {1'b0, r_den}) begin
                r_rem <= 32'(n_sh - {1'b0, r_den});
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= n_sh[31:0];
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end

endmodule
`default_nettype wire

@@ hdl/aarb_front.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// aarb_front
// Accepts items, reduces the angle, runs CORDIC, normalizes the axis and the
// CORDIC vector through square roots and dividers, then queues the job.
// ---------------------------------------------------------------------------
module aarb_front #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [111:0]        i_s_tdata,
    output logic                o_push,
    output aarb_pkg::t_rot_job  o_job,
    input  logic                i_full
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_RED   = 10'b0000000010,
        S_MUL   = 10'b0000000100,
        S_ITER  = 10'b0000001000,
        S_SQ    = 10'b0000010000,
        S_SUM   = 10'b0000100000,
        S_ROOT  = 10'b0001000000,
        S_DLOAD = 10'b0010000000,
        S_DIV   = 10'b0100000000,
        S_PUSH  = 10'b1000000000
    } t_front_state;

    t_front_state r_st;
    logic [4:0]   r_cnt;

    // input holding stage
    logic               r_hv;
    logic [111:0]       r_hdata;

    // working values
    logic signed [15:0] r_ang;
    logic signed [31:0] r_a   [3];
    logic [31:0]        r_mag [3];
    logic [63:0]        r_sq  [3];
    logic               r_neg [3];
    logic               r_degen;
    logic               r_unit;
    logic signed [13:0] r_m;
    logic               r_flip;
    logic [63:0]        r_len2;
    logic [63:0]        r_l2;
    logic [31:0]        r_mx;
    logic [4:0]         r_sh;
    logic signed [33:0] r_x;
    logic signed [33:0] r_y;
    logic signed [33:0] r_z;
    logic [31:0]        r_ax;
    logic [31:0]        r_ay;
    logic [63:0]        r_sqx;
    logic [63:0]        r_sqy;
    logic               r_xneg;
    logic               r_yneg;

    logic signed [17:0] n_av;
    logic signed [17:0] n_m0;
    logic signed [17:0] n_m1;
    logic signed [17:0] n_m;
    logic               n_flip;
    logic [31:0]        n_mag [3];
    logic signed [65:0] n_th;
    logic signed [65:0] n_zr;
    logic [31:0]        n_mx;
    logic signed [33:0] n_dx;
    logic signed [33:0] n_dy;
    logic signed [33:0] n_at;
    logic [31:0]        n_ax;
    logic [31:0]        n_ay;
    logic [63:0]        n_cs_sum;
    logic [63:0]        n_num_u [3];
    logic [63:0]        n_num_c;
    logic [63:0]        n_num_s;
    logic [31:0]        n_cm;
    logic [31:0]        n_sm;
    logic               n_take;

    aarb_pkg::t_iter_ctl w_root_ctl;
    aarb_pkg::t_iter_ctl w_div_ctl;
    logic [31:0]         w_root_axis;
    logic [31:0]         w_root_cs;
    logic [31:0]         w_quo_u [3];
    logic [31:0]         w_quo_c;
    logic [31:0]         w_quo_s;

    assign o_s_tready = !r_hv;
    assign n_take     = (r_st == S_IDLE) && r_hv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            r_hv <= 1'b1;
        end else if (n_take) begin
            r_hv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_hdata <= i_s_tdata;
        end
    end

    // angle reduction into [-90, 90] degrees
    always_comb begin
        n_av = 18'(r_ang);
        if (n_av >= 18'sd0) begin
            n_m0 = (n_av >= aarb_pkg::TURN_UNITS) ? n_av - aarb_pkg::TURN_UNITS : n_av;
        end else if (n_av >= -aarb_pkg::TURN_UNITS) begin
            n_m0 = n_av + aarb_pkg::TURN_UNITS;
        end else begin
            n_m0 = n_av + aarb_pkg::TWO_TURN_UNITS;
        end
        n_m1 = (n_m0 > aarb_pkg::HALF_UNITS) ? n_m0 - aarb_pkg::TURN_UNITS : n_m0;
        if (n_m1 > aarb_pkg::QUARTER_UNITS) begin
            n_m    = n_m1 - aarb_pkg::HALF_UNITS;
            n_flip = 1'b1;
        end else if (n_m1 < -aarb_pkg::QUARTER_UNITS) begin
            n_m    = n_m1 + aarb_pkg::HALF_UNITS;
            n_flip = 1'b1;
        end else begin
            n_m    = n_m1;
            n_flip = 1'b0;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_mag[k] = r_a[k][31] ? 32'(-r_a[k]) : 32'(r_a[k]);
        end
        n_mx = r_mag[0];
        if (r_mag[1] > n_mx) n_mx = r_mag[1];
        if (r_mag[2] > n_mx) n_mx = r_mag[2];
        n_th = 66'(r_m) * 66'($signed({1'b0, aarb_pkg::ANGLE_K}));
        n_zr = (n_th + 66'sd2147483648) >>> 32;
        n_dx = r_y >>> r_cnt;
        n_dy = r_x >>> r_cnt;
        n_at = $signed({2'b00, aarb_pkg::atan_q30(r_cnt)});
        n_ax = r_x[33] ? 32'(-r_x) : 32'(r_x);
        n_ay = r_y[33] ? 32'(-r_y) : 32'(r_y);
        n_cs_sum = r_sqx + r_sqy;
        for (int k = 0; k < 3; k++) begin
            n_num_u[k] = 64'({r_mag[k], 30'd0}) + 64'(w_root_axis[31:1]);
        end
        n_num_c = 64'({r_ax, 30'd0}) + 64'(w_root_cs[31:1]);
        n_num_s = 64'({r_ay, 30'd0}) + 64'(w_root_cs[31:1]);
    end

    always_comb begin
        w_root_ctl.load = (r_st == S_SUM);
        w_root_ctl.step = (r_st == S_ROOT);
        w_div_ctl.load  = (r_st == S_DLOAD);
        w_div_ctl.step  = (r_st == S_DIV);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_IDLE;
            r_cnt <= '0;
        end else begin
            unique case (r_st)
                S_IDLE:  if (r_hv) r_st <= S_RED;
                S_RED:   r_st <= S_MUL;
                S_MUL: begin
                    r_st  <= S_ITER;
                    r_cnt <= '0;
                end
                S_ITER: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) r_st <= S_SQ;
                end
                S_SQ:    r_st <= S_SUM;
                S_SUM: begin
                    r_st  <= S_ROOT;
                    r_cnt <= '0;
                end
                S_ROOT: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) r_st <= S_DLOAD;
                end
                S_DLOAD: begin
                    r_st  <= S_DIV;
                    r_cnt <= '0;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) r_st <= S_PUSH;
                end
                S_PUSH:  if (!i_full) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            S_IDLE: begin
                r_ang  <= $signed(r_hdata[15:0]);
                r_a[0] <= $signed(r_hdata[47:16]);
                r_a[1] <= $signed(r_hdata[79:48]);
                r_a[2] <= $signed(r_hdata[111:80]);
            end
            S_RED: begin
                r_m    <= 14'(n_m);
                r_flip <= n_flip;
                for (int k = 0; k < 3; k++) begin
                    r_mag[k] <= n_mag[k];
                    r_sq[k]  <= n_mag[k] * n_mag[k];
                    r_neg[k] <= r_a[k][31];
                end
                r_degen <= (r_a[0] == 32'sd0) && (r_a[1] == 32'sd0) && (r_a[2] == 32'sd0);
            end
            S_MUL: begin
                r_z    <= 34'(n_zr);
                r_x    <= aarb_pkg::Q30_ONE;
                r_y    <= '0;
                r_len2 <= r_sq[0] + r_sq[1] + r_sq[2];
                r_mx   <= n_mx;
                r_sh   <= '0;
            end
            S_ITER: begin
                if ({1'b0, r_cnt} < 6'(CORDIC_STEPS)) begin
                    if (!r_z[33]) begin
                        r_x <= r_x - n_dx;
                        r_y <= r_y + n_dy;
                        r_z <= r_z - n_at;
                    end else begin
                        r_x <= r_x + n_dx;
                        r_y <= r_y - n_dy;
                        r_z <= r_z + n_at;
                    end
                end
                // scale the axis until its largest component reaches 2^30
                if (!r_degen && !r_mx[31] && !r_mx[30]) begin
                    r_mx <= {r_mx[30:0], 1'b0};
                    for (int k = 0; k < 3; k++) begin
                        r_mag[k] <= {r_mag[k][30:0], 1'b0};
                    end
                    r_sh <= r_sh + 5'd1;
                end
            end
            S_SQ: begin
                r_ax   <= n_ax;
                r_ay   <= n_ay;
                r_sqx  <= n_ax * n_ax;
                r_sqy  <= n_ay * n_ay;
                r_xneg <= r_x[33];
                r_yneg <= r_y[33];
                r_l2   <= r_len2 << {r_sh, 1'b0};
                r_unit <= (r_len2 == 64'h1_0000_0000);
            end
            default: begin
            end
        endcase
    end

    aarb_isqrt u_root_axis (
        .i_clk  (i_clk),
        .i_ctl  (w_root_ctl),
        .i_val  (r_l2),
        .o_root (w_root_axis)
    );

    aarb_isqrt u_root_cs (
        .i_clk  (i_clk),
        .i_ctl  (w_root_ctl),
        .i_val  (n_cs_sum),
        .o_root (w_root_cs)
    );

    for (genvar g = 0; g < 3; g++) begin : g_div_u
        aarb_div u_div (
            .i_clk (i_clk),
            .i_ctl (w_div_ctl),
            .i_num (n_num_u[g]),
            .i_den (w_root_axis),
            .o_quo (w_quo_u[g])
        );
    end

    aarb_div u_div_c (
        .i_clk (i_clk),
        .i_ctl (w_div_ctl),
        .i_num (n_num_c),
        .i_den (w_root_cs),
        .o_quo (w_quo_c)
    );

    aarb_div u_div_s (
        .i_clk (i_clk),
        .i_ctl (w_div_ctl),
        .i_num (n_num_s),
        .i_den (w_root_cs),
        .o_quo (w_quo_s)
    );

    // assemble the job: pick the unit axis and clamp cosine and sine
    always_comb begin
        n_cm = (w_quo_c > 32'd1073741824) ? 32'd1073741824 : w_quo_c;
        n_sm = (w_quo_s > 32'd1073741824) ? 32'd1073741824 : w_quo_s;
        o_job.c     = (r_xneg ^ r_flip) ? -$signed(n_cm) : $signed(n_cm);
        o_job.s     = (r_yneg ^ r_flip) ? -$signed(n_sm) : $signed(n_sm);
        o_job.degen = r_degen;
        if (r_degen) begin
            o_job.ux = '0;
            o_job.uy = '0;
            o_job.uz = '0;
        end else if (r_unit) begin
            o_job.ux = 33'(r_a[0]) <<< 14;
            o_job.uy = 33'(r_a[1]) <<< 14;
            o_job.uz = 33'(r_a[2]) <<< 14;
        end else begin
            o_job.ux = r_neg[0] ? -$signed({1'b0, w_quo_u[0]}) : $signed({1'b0, w_quo_u[0]});
            o_job.uy = r_neg[1] ? -$signed({1'b0, w_quo_u[1]}) : $signed({1'b0, w_quo_u[1]});
            o_job.uz = r_neg[2] ? -$signed({1'b0, w_quo_u[2]}) : $signed({1'b0, w_quo_u[2]});
        end
    end

    assign o_push = (r_st == S_PUSH) && !i_full;

endmodule
`default_nettype wire

@@ hdl/aarb_queue.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// aarb_queue
// Two-entry job queue between the front and the back.
// ---------------------------------------------------------------------------
module aarb_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  aarb_pkg::t_rot_job  i_job,
    output logic                o_full,
    input  logic                i_pop,
    output aarb_pkg::t_rot_job  o_job,
    output logic                o_empty
);

    aarb_pkg::t_rot_job r_mem [2];
    logic               r_wp;
    logic               r_rp;
    logic [1:0]         r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

endmodule
`default_nettype wire

@@ hdl/aarb_back.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// aarb_back
// Forms the matrix products for one job and streams sixteen elements in
// row-major order through a registered output stage.
// ---------------------------------------------------------------------------
module aarb_back #(
    parameter int ELEMENT_FRAC_BITS = 30
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  aarb_pkg::t_rot_job  i_job,
    input  logic                i_empty,
    output logic                o_pop,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [39:0]         o_m_tdata,   // row[1:0], col[3:2], element[35:4]
    output logic                o_m_tuser,   // degenerate_axis
    output logic                o_m_tlast
);

    localparam int RSH = 30 - ELEMENT_FRAC_BITS;
    localparam logic signed [36:0] RND_HALF = 37'((2 ** RSH) / 2);

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_P1   = 4'b0010,
        B_P2   = 4'b0100,
        B_OUT  = 4'b1000
    } t_back_state;

    function automatic logic signed [34:0] mulq(input logic signed [35:0] a,
                                                input logic signed [35:0] b);
        logic signed [71:0] p;
        p = 72'(a) * 72'(b);
        return 35'((p + 72'sd536870912) >>> 30);
    endfunction

    t_back_state r_st;
    logic [3:0]  r_idx;

    aarb_pkg::t_rot_job r_job;
    logic signed [34:0] r_xx, r_yy, r_zz, r_xy, r_xz, r_yz;
    logic signed [34:0] r_xs, r_ys, r_zs;
    logic signed [32:0] r_omc;
    logic signed [34:0] r_xxo, r_yyo, r_zzo, r_xyo, r_xzo, r_yzo;

    logic               r_ov;
    logic [39:0]        r_odata;
    logic               r_ouser;
    logic               r_olast;

    logic signed [36:0] n_e;
    logic signed [36:0] n_c;
    logic signed [36:0] n_r;
    logic [31:0]        n_elem;
    logic               n_load;

    assign o_pop      = (r_st == B_IDLE) && !i_empty;
    assign n_load     = (r_st == B_OUT) && (!r_ov || i_m_tready);
    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;
    assign o_m_tlast  = r_olast;

    always_comb begin
        n_c = 37'(r_job.c);
        case (r_idx)
            4'd0:    n_e = 37'(r_xxo) + n_c;
            4'd1:    n_e = 37'(r_xyo) - 37'(r_zs);
            4'd2:    n_e = 37'(r_xzo) + 37'(r_ys);
            4'd4:    n_e = 37'(r_xyo) + 37'(r_zs);
            4'd5:    n_e = 37'(r_yyo) + n_c;
            4'd6:    n_e = 37'(r_yzo) - 37'(r_xs);
            4'd8:    n_e = 37'(r_xzo) - 37'(r_ys);
            4'd9:    n_e = 37'(r_yzo) + 37'(r_xs);
            4'd10:   n_e = 37'(r_zzo) + n_c;
            4'd15:   n_e = 37'(aarb_pkg::Q30_ONE);
            default: n_e = '0;
        endcase
        n_r = (n_e + RND_HALF) >>> RSH;
        if (n_r > 37'sd2147483647) begin
            n_elem = 32'h7FFF_FFFF;
        end else if (n_r < -37'sd2147483648) begin
            n_elem = 32'h8000_0000;
        end else begin
            n_elem = n_r[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= B_IDLE;
            r_idx <= '0;
        end else begin
            unique case (r_st)
                B_IDLE: if (!i_empty) r_st <= B_P1;
                B_P1:   r_st <= B_P2;
                B_P2: begin
                    r_st  <= B_OUT;
                    r_idx <= '0;
                end
                B_OUT: if (n_load) begin
                    r_idx <= r_idx + 4'd1;
                    if (r_idx == 4'd15) r_st <= B_IDLE;
                end
                default: r_st <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_job <= i_job;
        if (r_st == B_P1) begin
            r_xx  <= mulq(36'(r_job.ux), 36'(r_job.ux));
            r_yy  <= mulq(36'(r_job.uy), 36'(r_job.uy));
            r_zz  <= mulq(36'(r_job.uz), 36'(r_job.uz));
            r_xy  <= mulq(36'(r_job.ux), 36'(r_job.uy));
            r_xz  <= mulq(36'(r_job.ux), 36'(r_job.uz));
            r_yz  <= mulq(36'(r_job.uy), 36'(r_job.uz));
            r_xs  <= mulq(36'(r_job.ux), 36'(r_job.s));
            r_ys  <= mulq(36'(r_job.uy), 36'(r_job.s));
            r_zs  <= mulq(36'(r_job.uz), 36'(r_job.s));
            r_omc <= 33'(aarb_pkg::Q30_ONE) - 33'(r_job.c);
        end
        if (r_st == B_P2) begin
            r_xxo <= mulq(36'(r_xx), 36'(r_omc));
            r_yyo <= mulq(36'(r_yy), 36'(r_omc));
            r_zzo <= mulq(36'(r_zz), 36'(r_omc));
            r_xyo <= mulq(36'(r_xy), 36'(r_omc));
            r_xzo <= mulq(36'(r_xz), 36'(r_omc));
            r_yzo <= mulq(36'(r_yz), 36'(r_omc));
        end
    end

    // output stage: hold until taken, refill on the same edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (n_load) begin
            r_ov <= 1'b1;
        end else if (i_m_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_load) begin
            r_odata <= {4'b0000, n_elem, r_idx[1:0], r_idx[3:2]};
            r_ouser <= r_job.degen;
            r_olast <= (r_idx == 4'd15);
        end
    end

endmodule
`default_nettype wire

@@ hdl/axis_angle_rotation_build.sv @@
// Flow: the front works on one item at a time, in three phases (CORDIC
// rotation, bit-serial square roots, bit-serial dividers), and can hold
// one more accepted item meanwhile; the sixteen elements of an item then
// leave at one per cycle while the receiver asserts i_m_tready.
// Reset: synchronous, active low; clears handshake and sequencer state.
`default_nettype none
// ---------------------------------------------------------------------------
// axis_angle_rotation_build
// Builds the 4x4 homogeneous rotation matrix for an angle and an axis.
// ---------------------------------------------------------------------------
module axis_angle_rotation_build #(
    parameter int CORDIC_STEPS      = 24,
    parameter int ELEMENT_FRAC_BITS = 30
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [111:0]  i_s_tdata,   // angle_deg[15:0], axis_x[47:16],
                                       // axis_y[79:48], axis_z[111:80]
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [39:0]   o_m_tdata,   // row[1:0], col[3:2], element[35:4]
    output logic          o_m_tuser,   // degenerate_axis
    output logic          o_m_tlast
);

    aarb_pkg::t_rot_job w_push_job;
    aarb_pkg::t_rot_job w_pop_job;
    logic               w_push;
    logic               w_full;
    logic               w_pop;
    logic               w_empty;

    aarb_front #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_push     (w_push),
        .o_job      (w_push_job),
        .i_full     (w_full)
    );

    aarb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_job   (w_pop_job),
        .o_empty (w_empty)
    );

    aarb_back #(
        .ELEMENT_FRAC_BITS (ELEMENT_FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (w_pop_job),
        .i_empty    (w_empty),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
`default_nettype wire
